// ===== design/encoder_speed_trimmed_mean_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Encoder speed trimmed mean filter: assertion macros
// Shared property wrappers on aclk for the filter's RTL.
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_TRIMMED_MEAN_FILTER_TOP_DEFINES_SVH
`define ENCODER_SPEED_TRIMMED_MEAN_FILTER_TOP_DEFINES_SVH

// Check a property while out of reset
`define ESF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included
`define ESF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== design/esf_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder speed filter package
// Widths, reciprocal constants, state type and window control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package esf_pkg;

    // Count and window geometry
    localparam int CNT_W   = 16;
    localparam int DEPTH   = 5;
    localparam int SCAN_W  = 3;
    // Sum of DEPTH counts, signed
    localparam int SUM_W   = 19;

    // Divide by 5: multiply by ceil(2^20/5), exact for magnitudes below 2^18
    localparam int MAG5_W   = 18;
    localparam int RECIP5_W = 18;
    localparam int SHIFT5   = 20;
    localparam logic [RECIP5_W-1:0] RECIP5 = 18'd209716;
    localparam int PROD5_W  = MAG5_W + RECIP5_W;

    // Divide by 3: multiply by ceil(2^17/3), exact for magnitudes below 2^17
    localparam int MAG3_W   = 17;
    localparam int RECIP3_W = 16;
    localparam int SHIFT3   = 17;
    localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;
    localparam int PROD3_W  = MAG3_W + RECIP3_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLEND,
        ST_INSERT,
        ST_SCAN,
        ST_TRIM,
        ST_DIV,
        ST_DONE
    } state_t;

    // Control from the sequencer to the row of cells
    typedef struct packed {
        logic insert;
        logic scan;
        logic scan_first;
    } win_ctrl_t;

endpackage

`default_nettype wire

// ===== design/esf_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one blended sample and takes its neighbor's sample on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module esf_cell (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     shift_en,
    input  wire logic [esf_pkg::CNT_W-1:0] d_in,
    output logic      [esf_pkg::CNT_W-1:0] q
);
    import esf_pkg::*;

    logic [CNT_W-1:0] sample_reg;

    // Take the neighbor's sample on shift; window starts cleared
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (shift_en) begin
            sample_reg <= d_in;
        end
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

// ===== design/esf_window.sv =====
// ----------------------------------------------------------------------------
// Sample window
// Row of cells: insert drops the oldest sample, scan rotates the row once
// and collects sum, minimum and maximum from the tail cell.
// ----------------------------------------------------------------------------
`default_nettype none

module esf_window (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire esf_pkg::win_ctrl_t        ctrl,
    input  wire logic [esf_pkg::CNT_W-1:0] new_sample,
    output logic      [esf_pkg::SUM_W-1:0] trim_sum
);
    import esf_pkg::*;

    logic [CNT_W-1:0]        cell_q [DEPTH];
    logic [CNT_W-1:0]        cell_d [DEPTH];
    logic                    shift_en;
    logic [CNT_W-1:0]        tail;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [CNT_W-1:0] min_reg;
    logic signed [CNT_W-1:0] min_next;
    logic signed [CNT_W-1:0] max_reg;
    logic signed [CNT_W-1:0] max_next;

    assign shift_en = ctrl.insert | ctrl.scan;
    assign tail     = cell_q[DEPTH-1];

    // Feed the head with the new sample or wrap the tail around
    always_comb begin
        cell_d[0] = ctrl.insert ? new_sample : tail;
        for (int i = 1; i < DEPTH; i++) begin
            cell_d[i] = cell_q[i-1];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        esf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .d_in     (cell_d[g]),
            .q        (cell_q[g])
        );
    end

    // Accumulate the tail sample, restarting on the first scan cycle
    always_comb begin
        sum_next = sum_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.scan) begin
            if (ctrl.scan_first) begin
                sum_next = SUM_W'($signed(tail));
                min_next = $signed(tail);
                max_next = $signed(tail);
            end else begin
                sum_next = sum_reg + SUM_W'($signed(tail));
                if ($signed(tail) < min_reg) begin
                    min_next = $signed(tail);
                end
                if ($signed(tail) > max_reg) begin
                    max_next = $signed(tail);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        min_reg <= min_next;
        max_reg <= max_next;
    end

    // Drop one largest and one smallest sample
    assign trim_sum = sum_reg - SUM_W'(min_reg) - SUM_W'(max_reg);

endmodule

`default_nettype wire

// ===== design/encoder_speed_trimmed_mean_filter_top.sv =====
// ----------------------------------------------------------------------------
// Encoder speed trimmed mean filter
// Low-pass blend of encoder counts followed by a five-sample trimmed mean.
// ----------------------------------------------------------------------------
// Each request carries one signed period count. The count is optionally
// negated (saturating), blended with the last output as (4*new+prev)/5,
// shifted into a five-cell window, and the output is the window sum less
// its largest and smallest samples, divided by three, truncated toward zero.
// After acceptance a request passes through one blend multiply, one insert,
// a scan that rotates the row of five cells once past the accumulator, one
// trim, one divide multiply and one output load into the output register.
// A new request is taken once the previous result is in the output
// register; a result that is not taken stalls the next one in its load
// cycle. The window and the last output reset to zero.
`default_nettype none

module encoder_speed_trimmed_mean_filter_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Slave side: [15:0] raw_count
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [esf_pkg::CNT_W-1:0] s_tdata,
    // Master side: [15:0] filtered_speed
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [esf_pkg::CNT_W-1:0] m_tdata,
    // Configuration: invert_direction
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_wdata
);
    import esf_pkg::*;

    `include "encoder_speed_trimmed_mean_filter_top_defines.svh"

    state_t            state_reg;
    state_t            state_next;
    logic [SCAN_W-1:0] scan_cnt_reg;
    logic [SCAN_W-1:0] scan_cnt_next;
    logic              invert_reg;
    win_ctrl_t         win_ctrl;
    logic              accept;
    logic              load_out;

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   prev_reg;
    logic [SUM_W-1:0]   blend_sum;
    logic [SUM_W-1:0]   blend_abs;
    logic [PROD5_W-1:0] prod5_reg;
    logic               sign5_reg;
    logic [CNT_W-1:0]   blend_q;
    logic [CNT_W-1:0]   blend_val;
    logic [SUM_W-1:0]   trim_sum;
    logic [SUM_W-1:0]   trim_abs;
    logic [MAG3_W-1:0]  mag3_reg;
    logic               sign3_reg;
    logic [PROD3_W-1:0] prod3_reg;
    logic [CNT_W-1:0]   res_q;
    logic [CNT_W-1:0]   res_val;
    logic               m_tvalid_reg;
    logic [CNT_W-1:0]   m_tdata_reg;

    // Next state
    always_comb begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                state_next    = ST_SCAN;
                scan_cnt_next = '0;
            end
            ST_SCAN: begin
                if (scan_cnt_reg == SCAN_W'(DEPTH - 1)) begin
                    state_next = ST_TRIM;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_TRIM: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready            = 1'b0;
        load_out            = 1'b0;
        win_ctrl.insert     = 1'b0;
        win_ctrl.scan       = 1'b0;
        win_ctrl.scan_first = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_INSERT: begin
                win_ctrl.insert = 1'b1;
            end
            ST_SCAN: begin
                win_ctrl.scan       = 1'b1;
                win_ctrl.scan_first = (scan_cnt_reg == '0);
            end
            ST_DONE: begin
                load_out = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            invert_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cfg_we) begin
                invert_reg <= cfg_wdata;
            end
        end
    end

    // Negate on request, saturating the most negative count
    always_comb begin
        cnt_next = s_tdata;
        if (invert_reg) begin
            if (s_tdata == {1'b1, {(CNT_W-1){1'b0}}}) begin
                cnt_next = {1'b0, {(CNT_W-1){1'b1}}};
            end else begin
                cnt_next = ~s_tdata + 1'b1;
            end
        end
    end

    // Blend 4*new + prev and take its magnitude
    assign blend_sum = {{(SUM_W-CNT_W-2){cnt_reg[CNT_W-1]}}, cnt_reg, 2'b00}
                     + {{(SUM_W-CNT_W){prev_reg[CNT_W-1]}}, prev_reg};
    assign blend_abs = blend_sum[SUM_W-1] ? (~blend_sum + 1'b1) : blend_sum;

    // Restore the sign of the quotient by five
    assign blend_q   = prod5_reg[SHIFT5 +: CNT_W];
    assign blend_val = sign5_reg ? (~blend_q + 1'b1) : blend_q;

    // Magnitude of the trimmed sum, then quotient by three
    assign trim_abs  = trim_sum[SUM_W-1] ? (~trim_sum + 1'b1) : trim_sum;
    assign res_q     = prod3_reg[SHIFT3 +: CNT_W];
    assign res_val   = sign3_reg ? (~res_q + 1'b1) : res_q;

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cnt_reg <= cnt_next;
        end
        if (state_reg == ST_BLEND) begin
            sign5_reg <= blend_sum[SUM_W-1];
            prod5_reg <= blend_abs[MAG5_W-1:0] * RECIP5;
        end
        if (state_reg == ST_TRIM) begin
            sign3_reg <= trim_sum[SUM_W-1];
            mag3_reg  <= trim_abs[MAG3_W-1:0];
        end
        if (state_reg == ST_DIV) begin
            prod3_reg <= mag3_reg * RECIP3;
        end
        if (load_out) begin
            m_tdata_reg <= res_val;
        end
    end

    // Last output feeds the next blend; output valid is held until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                prev_reg     <= res_val;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    esf_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (win_ctrl),
        .new_sample (blend_val),
        .trim_sum   (trim_sum)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Assertions
    `ESF_ASSERT(a_accept_to_blend, (s_tvalid && s_tready) |=> (state_reg == ST_BLEND), "request not followed by blend")
    `ESF_ASSERT(a_done_holds, (state_reg == ST_DONE && m_tvalid && !m_tready) |=> (state_reg == ST_DONE), "result loaded over a pending one")
    `ESF_ASSERT(a_scan_bound, (state_reg == ST_SCAN) |-> (scan_cnt_reg < SCAN_W'(DEPTH)), "scan count past window depth")
    `ESF_ASSERT(a_prev_matches_out, m_tvalid |-> (prev_reg == m_tdata), "feedback differs from output")
    `ESF_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_tvalid), "not idle after reset")

endmodule

`default_nettype wire
